// ----- src/b32sc_pkg.sv -----
package b32sc_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_Z   = 8'h5a;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LZ  = 8'h7a;
    localparam logic [7:0] CH_2   = 8'h32;
    localparam logic [7:0] CH_7   = 8'h37;
    localparam logic [7:0] CH_PAD = 8'h3d;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [4:0] ALPHA_LETTERS = 5'd26;
    localparam logic [5:0] ALPHA_NONE = 6'd32;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2
    } t_status;

    // One accepted item's worth of results: data characters/bytes first,
    // then '=' fill, then an optional status marker.
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      nd;
        logic [2:0]      npad;
        logic            mark;
        t_status         status;
        logic            last;
    } t_job;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

    function automatic logic [7:0] alpha_char(input logic [4:0] idx);
        if (idx < ALPHA_LETTERS) begin
            return CH_A + {3'b000, idx};
        end
        return CH_2 + {3'b000, idx - ALPHA_LETTERS};
    endfunction

    // 0..31, or ALPHA_NONE outside the alphabet
    function automatic logic [5:0] alpha_value(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[CH_A:CH_Z]}) begin
            d = c - CH_A;
            return d[5:0];
        end
        if (c inside {[CH_2:CH_7]}) begin
            d = c - CH_2 + {3'b000, ALPHA_LETTERS};
            return d[5:0];
        end
        return ALPHA_NONE;
    endfunction

    function automatic logic bad_group(input logic [2:0] gp);
        return gp inside {3'd1, 3'd3, 3'd6};
    endfunction

endpackage

// ----- src/b32sc_front.sv -----
module b32sc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_data,
    input  logic             i_in_valid,
    input  logic [7:0]       i_in_value,
    input  logic             i_in_last,
    input  logic             i_q_full,
    output logic             o_in_stall,
    output logic             o_push,
    output b32sc_pkg::t_job  o_job
);
    import b32sc_pkg::*;

    logic       r_mode, n_mode;
    logic [6:0] r_bits, n_bits;
    logic [2:0] r_count, n_count;
    logic [2:0] r_gp, n_gp;
    logic       r_pad, n_pad;
    logic       r_err, n_err;

    logic in_fire;

    assign o_in_stall = i_q_full;
    assign in_fire    = i_in_valid && !i_q_full;

    always_comb begin
        logic [11:0] wbuf;
        logic [3:0]  wcnt;
        logic [2:0]  gp;
        logic [3:0]  room;
        logic [2:0]  pad;
        logic [7:0]  c;
        logic [5:0]  v;
        logic        clear;
        logic        errd;
        wbuf  = 12'd0;
        wcnt  = 4'd0;
        gp    = r_gp;
        room  = 4'd0;
        pad   = 3'd0;
        c     = i_in_value;
        v     = 6'd0;
        clear = 1'b0;
        errd  = 1'b0;
        n_mode  = r_mode;
        n_bits  = r_bits;
        n_count = r_count;
        n_gp    = r_gp;
        n_pad   = r_pad;
        n_err   = r_err;
        o_push  = 1'b0;
        o_job   = '0;
        o_job.status = ST_OK;

        if (in_fire && !r_mode) begin
            // encode: one or two characters per byte, plus the tail on last
            o_push = 1'b1;
            wbuf = {r_bits[3:0], i_in_value};
            wcnt = {1'b0, r_count} + 4'd8;
            o_job.data[0] = alpha_char(5'(wbuf >> (wcnt - 4'd5)));
            o_job.nd = 2'd1;
            wcnt = wcnt - 4'd5;
            gp = gp + 3'd1;
            if (wcnt >= 4'd5) begin
                o_job.data[1] = alpha_char(5'(wbuf >> (wcnt - 4'd5)));
                o_job.nd = 2'd2;
                wcnt = wcnt - 4'd5;
                gp = gp + 3'd1;
            end
            wbuf = wbuf & ((12'd1 << wcnt) - 12'd1);
            if (i_in_last) begin
                if (wcnt != 4'd0) begin
                    o_job.data[o_job.nd] = alpha_char(5'(wbuf << (4'd5 - wcnt)));
                    o_job.nd = o_job.nd + 2'd1;
                    gp = gp + 3'd1;
                end
                pad  = 3'd0 - gp;
                room = 4'd8 - {2'b00, o_job.nd};
                if ({1'b0, pad} > room) begin
                    pad = room[2:0];
                end
                o_job.npad = pad;
                o_job.last = 1'b1;
                clear = 1'b1;
            end else begin
                n_bits  = wbuf[6:0];
                n_count = wcnt[2:0];
                n_gp    = gp;
            end
        end else if (in_fire) begin
            if (c inside {[CH_LA:CH_LZ]}) begin
                c = c - CASE_OFFSET;
            end
            if (r_err) begin
                // discard until the end of the message
                if (i_in_last) begin
                    o_push = 1'b1;
                    o_job.mark = 1'b1;
                    o_job.last = 1'b1;
                    clear = 1'b1;
                end
            end else if (c == CH_PAD) begin
                if (!r_pad) begin
                    n_pad   = 1'b1;
                    n_bits  = 7'd0;
                    n_count = 3'd0;
                    if (r_gp == 3'd0 || bad_group(r_gp)) begin
                        errd = 1'b1;
                        o_job.status = ST_BAD_LEN;
                    end
                end
                if (errd || i_in_last) begin
                    o_push = 1'b1;
                    o_job.mark = 1'b1;
                    o_job.last = i_in_last;
                    clear = i_in_last;
                    n_err = errd;
                end
            end else begin
                v = alpha_value(c);
                if (r_pad || v[5]) begin
                    o_push = 1'b1;
                    o_job.mark = 1'b1;
                    o_job.status = ST_BAD_CHAR;
                    o_job.last = i_in_last;
                    clear = i_in_last;
                    n_err = 1'b1;
                end else begin
                    wbuf = {r_bits, v[4:0]};
                    wcnt = {1'b0, r_count} + 4'd5;
                    if (wcnt >= 4'd8) begin
                        o_job.data[0] = 8'(wbuf >> (wcnt - 4'd8));
                        o_job.nd = 2'd1;
                        wcnt = wcnt - 4'd8;
                    end
                    wbuf = wbuf & ((12'd1 << wcnt) - 12'd1);
                    gp = r_gp + 3'd1;
                    if (i_in_last) begin
                        o_push = 1'b1;
                        o_job.last = 1'b1;
                        clear = 1'b1;
                        if (bad_group(gp)) begin
                            o_job.mark = 1'b1;
                            o_job.status = ST_BAD_LEN;
                        end else if (o_job.nd == 2'd0) begin
                            o_job.mark = 1'b1;
                        end
                    end else begin
                        o_push  = (o_job.nd != 2'd0);
                        n_bits  = wbuf[6:0];
                        n_count = wcnt[2:0];
                        n_gp    = gp;
                    end
                end
            end
        end

        if (clear || i_cfg_valid) begin
            n_bits  = 7'd0;
            n_count = 3'd0;
            n_gp    = 3'd0;
            n_pad   = 1'b0;
            n_err   = 1'b0;
        end
        if (i_cfg_valid) begin
            n_mode = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_bits  <= 7'd0;
            r_count <= 3'd0;
            r_gp    <= 3'd0;
            r_pad   <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_bits  <= n_bits;
            r_count <= n_count;
            r_gp    <= n_gp;
            r_pad   <= n_pad;
            r_err   <= n_err;
        end
    end

endmodule

// ----- src/b32sc_queue.sv -----
module b32sc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b32sc_pkg::t_job       i_job,
    input  logic                  i_pop,
    output b32sc_pkg::t_job       o_job,
    output b32sc_pkg::t_q_status  o_status
);
    import b32sc_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;
    assign o_job          = r_mem[r_rd];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ----- src/b32sc_back.sv -----
module b32sc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b32sc_pkg::t_job       i_job,
    input  b32sc_pkg::t_q_status  i_q_status,
    output logic                  o_pop,
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic [7:0]            o_out_value,
    output logic                  o_out_valid,
    output logic                  o_out_last,
    output logic [1:0]            o_out_status
);
    import b32sc_pkg::*;

    logic       r_busy, n_busy;
    t_job       r_job, n_job;
    logic [2:0] r_idx, n_idx;

    logic [3:0] total;
    logic [3:0] idx_w;
    logic [3:0] data_end;
    logic [3:0] pad_end;
    logic       at_end;
    logic       res_fire;

    assign data_end = {2'b00, r_job.nd};
    assign pad_end  = data_end + {1'b0, r_job.npad};
    assign total    = pad_end + {3'b000, r_job.mark};
    assign idx_w    = {1'b0, r_idx};
    assign at_end   = (idx_w == total - 4'd1);
    assign res_fire = r_busy && !i_res_stall;
    assign o_pop    = !i_q_status.empty && (!r_busy || (res_fire && at_end));

    assign o_res_valid = r_busy;

    always_comb begin
        o_out_last   = r_job.last && at_end;
        o_out_status = ST_OK;
        if (idx_w < data_end) begin
            o_out_value = r_job.data[r_idx[1:0]];
            o_out_valid = 1'b1;
        end else if (idx_w < pad_end) begin
            o_out_value = CH_PAD;
            o_out_valid = 1'b1;
        end else begin
            o_out_value  = 8'd0;
            o_out_valid  = 1'b0;
            o_out_status = r_job.status;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_job  = r_job;
        n_idx  = r_idx;
        if (o_pop) begin
            n_busy = 1'b1;
            n_job  = i_job;
            n_idx  = 3'd0;
        end else if (res_fire && at_end) begin
            n_busy = 1'b0;
        end else if (res_fire) begin
            n_idx = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

endmodule

// ----- src/base32_stream_codec.sv -----
// Streaming Base32 encoder/decoder (alphabet A-Z, 2-7, '=' fill).
// Input channel: i_in_valid / o_in_stall with i_in_value and i_in_last.
//   An item is taken on a clock edge with valid high and stall low.
// Result channel: o_res_valid / i_res_stall with o_out_value, o_out_valid,
//   o_out_last and o_out_status. The payload holds while stalled.
// Config channel: i_cfg_valid / o_cfg_ready (always ready), i_cfg_data is
//   the mode bit (0 encode, 1 decode). A write also clears message state;
//   write only while no results are pending.
// The first result of an item shows up once the item has been written into the
//   queue and then loaded into the output sequencer's job register. Each item
//   expands into 0 to 8 results; the output stage delivers one result per cycle
//   while the receiver does not stall (about 1.6 characters per byte in encode
//   mode). A 4-entry item queue sits between the classifier and the output
//   sequencer; inputs are taken every cycle until that queue fills, and
//   o_in_stall follows queue full.
// Reset (synchronous, active low) selects encode mode and empties the queue.
// When the receiver stalls, the output sequencer holds, the queue fills, and
// then the input side stalls; nothing is dropped.
module base32_stream_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_value,
    input  logic       i_in_last,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_out_value,
    output logic       o_out_valid,
    output logic       o_out_last,
    output logic [1:0] o_out_status
);
    import b32sc_pkg::*;

    t_job      front_job;
    t_job      head_job;
    t_q_status q_stat;
    logic      push;
    logic      pop;

    assign o_cfg_ready = 1'b1;

    b32sc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_value  (i_in_value),
        .i_in_last   (i_in_last),
        .i_q_full    (q_stat.full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_job       (front_job)
    );

    b32sc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_stat)
    );

    b32sc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_q_status   (q_stat),
        .o_pop        (pop),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_out_value  (o_out_value),
        .o_out_valid  (o_out_valid),
        .o_out_last   (o_out_last),
        .o_out_status (o_out_status)
    );

    a_status_is_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && (o_out_status != ST_OK) |-> !o_out_valid)
        else $error("error status on a data result");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_out_valid |-> (o_out_value == 8'd0))
        else $error("marker result carries a nonzero value");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CNT_W'(Q_DEPTH))
        else $error("item queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("item pushed into a full queue");

endmodule

// ----- tb/sv/b32_check_pkg.sv -----
`timescale 1ns / 1ps
package b32_check_pkg;
    import b32sc_pkg::*;

    typedef struct packed {
        logic [7:0] value;
        logic       valid;
        logic       last;
        t_status    status;
    } t_codec_result;

    class b32_scoreboard;
        t_codec_result expected_outputs[$];
        int            mismatches;
        logic          decoding;
        logic [11:0]   bit_buf;
        logic [3:0]    bit_cnt;
        logic [2:0]    group_pos;
        logic          pad_seen;
        logic          err_seen;

        function new();
            mismatches = 0;
            decoding   = 1'b0;
            clear_message();
        endfunction

        function void clear_message();
            bit_buf   = '0;
            bit_cnt   = '0;
            group_pos = '0;
            pad_seen  = 1'b0;
            err_seen  = 1'b0;
        endfunction

        function void set_mode(logic decode);
            decoding = decode;
            clear_message();
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void push(logic [7:0] value, logic valid, logic last, t_status status);
            t_codec_result r;
            r.value  = value;
            r.valid  = valid;
            r.last   = last;
            r.status = status;
            expected_outputs.insert(expected_outputs.size(), r);
        endfunction

        function void mark_tail_last();
            expected_outputs[expected_outputs.size() - 1].last = 1'b1;
        endfunction

        function logic [7:0] symbol_for(logic [4:0] idx);
            if (idx < ALPHA_LETTERS) begin
                return CH_A + 8'(idx);
            end
            return CH_2 + 8'(idx - ALPHA_LETTERS);
        endfunction

        // 0..31 for alphabet characters, ALPHA_NONE otherwise
        function logic [5:0] value_of(logic [7:0] ch);
            if (ch >= CH_A && ch <= CH_Z) begin
                return 6'(ch - CH_A);
            end
            if (ch >= CH_2 && ch <= CH_7) begin
                return 6'(ch - CH_2) + 6'(ALPHA_LETTERS);
            end
            return ALPHA_NONE;
        endfunction

        function logic short_group(logic [2:0] gp);
            return gp == 3'd1 || gp == 3'd3 || gp == 3'd6;
        endfunction

        function void encode_byte(logic [7:0] b, logic last);
            logic [11:0] shifted;
            int          produced;
            produced = 0;
            // at most 4 bits are carried, so the top bits fall off cleanly
            bit_buf = {bit_buf[3:0], b};
            bit_cnt = bit_cnt + 4'd8;
            while (bit_cnt >= 4'd5) begin
                shifted = bit_buf >> (bit_cnt - 4'd5);
                push(symbol_for(shifted[4:0]), 1'b1, 1'b0, ST_OK);
                produced++;
                bit_cnt   = bit_cnt - 4'd5;
                group_pos = group_pos + 3'd1;
            end
            bit_buf = bit_buf & ((12'd1 << bit_cnt) - 12'd1);
            if (last) begin
                if (bit_cnt != 4'd0) begin
                    shifted = bit_buf << (4'd5 - bit_cnt);
                    push(symbol_for(shifted[4:0]), 1'b1, 1'b0, ST_OK);
                    produced++;
                    group_pos = group_pos + 3'd1;
                end
                while (group_pos != 3'd0) begin
                    push(CH_PAD, 1'b1, 1'b0, ST_OK);
                    produced++;
                    group_pos = group_pos + 3'd1;
                end
                if (produced > 0) begin
                    mark_tail_last();
                end
                clear_message();
            end
        endfunction

        function void raise_error(logic last, t_status status);
            push(8'd0, 1'b0, last, status);
            err_seen = 1'b1;
            if (last) begin
                clear_message();
            end
        endfunction

        function void decode_char(logic [7:0] c, logic last);
            logic [7:0]  ch;
            logic [5:0]  sym;
            logic [11:0] shifted;
            int          produced;
            produced = 0;
            if (err_seen) begin
                if (last) begin
                    push(8'd0, 1'b0, 1'b1, ST_OK);
                    clear_message();
                end
                return;
            end
            ch = c;
            if (ch >= CH_LA && ch <= CH_LZ) begin
                ch = ch - CASE_OFFSET;
            end
            if (ch == CH_PAD) begin
                // only the first '=' matters; the rest of the fill is not counted
                if (!pad_seen) begin
                    pad_seen = 1'b1;
                    bit_buf  = '0;
                    bit_cnt  = '0;
                    if (group_pos == 3'd0 || short_group(group_pos)) begin
                        raise_error(last, ST_BAD_LEN);
                        return;
                    end
                end
            end else begin
                sym = value_of(ch);
                if (pad_seen || sym[5]) begin
                    raise_error(last, ST_BAD_CHAR);
                    return;
                end
                bit_buf = {bit_buf[6:0], sym[4:0]};
                bit_cnt = bit_cnt + 4'd5;
                if (bit_cnt >= 4'd8) begin
                    shifted = bit_buf >> (bit_cnt - 4'd8);
                    push(shifted[7:0], 1'b1, 1'b0, ST_OK);
                    produced++;
                    bit_cnt = bit_cnt - 4'd8;
                end
                bit_buf   = bit_buf & ((12'd1 << bit_cnt) - 12'd1);
                group_pos = group_pos + 3'd1;
            end
            if (last) begin
                if (!pad_seen && short_group(group_pos)) begin
                    raise_error(1'b1, ST_BAD_LEN);
                    return;
                end
                if (produced > 0) begin
                    mark_tail_last();
                end else begin
                    push(8'd0, 1'b0, 1'b1, ST_OK);
                end
                clear_message();
            end
        endfunction

        function void note_item(logic [7:0] value, logic last);
            if (decoding) begin
                decode_char(value, last);
            end else begin
                encode_byte(value, last);
            end
        endfunction

        function void check_result(logic [7:0] value, logic valid, logic last,
                                   logic [1:0] status);
            t_codec_result want;
            if (expected_outputs.size() == 0) begin
                $display("%0t: unexpected result value=%02h valid=%0b last=%0b status=%0d",
                         $time, value, valid, last, status);
                mismatches++;
                return;
            end
            want = expected_outputs.pop_front();
            if (want.value !== value) begin
                $display("%0t: out_value expected %02h actual %02h", $time, want.value, value);
                mismatches++;
            end
            if (want.valid !== valid) begin
                $display("%0t: out_valid expected %0b actual %0b", $time, want.valid, valid);
                mismatches++;
            end
            if (want.last !== last) begin
                $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
                mismatches++;
            end
            if (want.status !== status) begin
                $display("%0t: out_status expected %0d actual %0d", $time, want.status, status);
                mismatches++;
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
    import b32sc_pkg::*;
    import b32_check_pkg::*;

    localparam logic MODE_ENCODE    = 1'b0;
    localparam logic MODE_DECODE    = 1'b1;
    localparam int   DRAIN_CYCLES   = 16;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   RANDOM_ITEMS   = 120;  // per phase, four phases

    typedef enum int {
        STALL_NONE,
        STALL_SPARSE,
        STALL_RUNS
    } t_stall_style;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_value  = 8'd0;
    logic       i_in_last   = 1'b0;
    logic       i_res_stall = 1'b0;
    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_res_valid;
    logic [7:0] o_out_value;
    logic       o_out_valid;
    logic       o_out_last;
    logic [1:0] o_out_status;

    b32_scoreboard sb;
    int            burst_left  = 0;
    int            items_sent  = 0;
    int            idle_cycles = 0;
    t_stall_style  stall_style = STALL_NONE;
    int            style_timer = 0;
    int            stall_run   = 0;

    base32_stream_codec dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_value   (i_in_value),
        .i_in_last    (i_in_last),
        .o_res_valid  (o_res_valid),
        .i_res_stall  (i_res_stall),
        .o_out_value  (o_out_value),
        .o_out_valid  (o_out_valid),
        .o_out_last   (o_out_last),
        .o_out_status (o_out_status)
    );

    always #5 i_clk = ~i_clk;

    // receiver: style changes every so often (free-flowing, scattered stalls, long runs)
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_stall <= 1'b0;
        end else begin
            if (style_timer == 0) begin
                stall_style = t_stall_style'($urandom_range(0, 2));
                style_timer = $urandom_range(50, 250);
            end else begin
                style_timer--;
            end
            case (stall_style)
                STALL_NONE: begin
                    i_res_stall <= 1'b0;
                end
                STALL_SPARSE: begin
                    i_res_stall <= ($urandom_range(0, 2) == 0);
                end
                default: begin
                    if (stall_run == 0) begin
                        i_res_stall <= ~i_res_stall;
                        stall_run = $urandom_range(1, 8);
                    end else begin
                        stall_run--;
                    end
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_item(i_in_value, i_in_last);
            end
            if (o_res_valid && !i_res_stall) begin
                sb.check_result(o_out_value, o_out_valid, o_out_last, o_out_status);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_res_valid && !i_res_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog expired, %0d results outstanding", $time, sb.pending());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // sender works in bursts; a gap between bursts drops valid
    task automatic send_item(logic [7:0] value, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_value <= value;
        i_in_last  <= last;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // one message, bytes taken most significant first, last on the final one
    task automatic send_packed(logic [63:0] bytes, int count);
        for (int k = 0; k < count; k++) begin
            send_item(bytes[8 * (count - 1 - k) +: 8], k == count - 1);
        end
    endtask

    task automatic settle(int extra);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_mode(logic decode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= decode;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_mode(decode);
    endtask

    function automatic logic [7:0] random_symbol();
        logic [4:0] idx;
        logic [7:0] ch;
        idx = 5'($urandom_range(0, 31));
        if (idx < ALPHA_LETTERS) begin
            ch = CH_A + 8'(idx);
            if ($urandom_range(0, 2) == 0) begin
                ch = ch + CASE_OFFSET;
            end
        end else begin
            ch = CH_2 + 8'(idx - ALPHA_LETTERS);
        end
        return ch;
    endfunction

    task automatic send_plain_message();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
            send_item(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // groups of valid lengths with random content and varied fill; now and then one item is corrupted
    task automatic send_b32_message();
        int         tail_len;
        int         chars;
        int         pads;
        int         bad_at;
        logic [7:0] ch;
        case ($urandom_range(0, 4))
            0:       tail_len = 2;
            1:       tail_len = 4;
            2:       tail_len = 5;
            3:       tail_len = 7;
            default: tail_len = 8;
        endcase
        chars = 8 * $urandom_range(0, 2) + tail_len;
        case ($urandom_range(0, 5))
            0, 1, 2: pads = 8 - tail_len;
            3:       pads = 0;
            4:       pads = (tail_len == 8) ? 0 : 1;
            default: pads = $urandom_range(1, 3);
        endcase
        bad_at = -1;
        if ($urandom_range(0, 7) == 0) begin
            bad_at = $urandom_range(0, chars + pads - 1);
        end
        for (int k = 0; k < chars + pads; k++) begin
            ch = (k < chars) ? random_symbol() : CH_PAD;
            if (k == bad_at) begin
                ch = 8'($urandom_range(0, 255));
            end
            send_item(ch, k == chars + pads - 1);
        end
    endtask

    task automatic send_noise();
        int         len;
        logic [7:0] ch;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(0, 2))
                0:       ch = 8'($urandom_range(0, 255));
                1:       ch = CH_PAD;
                default: ch = random_symbol();
            endcase
            send_item(ch, k == len - 1);
        end
    endtask

    task automatic run_random(logic decode, int count);
        int target;
        target = items_sent + count;
        while (items_sent < target) begin
            if (!decode) begin
                send_plain_message();
            end else if ($urandom_range(0, 9) < 7) begin
                send_b32_message();
            end else begin
                send_noise();
            end
        end
    endtask

    task automatic run_phase(logic decode);
        run_random(decode, RANDOM_ITEMS / 2);
        settle(0);
        run_random(decode, RANDOM_ITEMS / 2);
    endtask

    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(MODE_ENCODE);
        send_packed(64'h00, 1);
        send_packed(64'hff, 1);
        send_packed(64'h00ff, 2);
        send_packed(64'hff00ff, 3);
        send_packed(64'h80017ffe, 4);
        send_packed(64'h123456789a, 5);
        send_packed("foobar", 6);
        run_phase(MODE_ENCODE);
        settle(DRAIN_CYCLES);

        write_mode(MODE_DECODE);
        send_packed("Ae", 2);
        send_packed("7z==", 4);     // second '=' is last: bare end marker
        send_packed("=", 1);        // fill at the start of a group
        send_packed("A=", 2);       // fill after one character
        send_packed("ABC", 3);      // unpadded tail of three
        send_packed("1A", 2);       // bad character, then discard until last
        send_packed("AB=C", 4);     // data after fill
        send_packed("@", 1);
        run_phase(MODE_DECODE);
        // leave a message open; the mode write has to drop it
        for (int k = 0; k < 3; k++) begin
            send_item(random_symbol(), 1'b0);
        end
        settle(DRAIN_CYCLES);

        write_mode(MODE_ENCODE);
        run_phase(MODE_ENCODE);
        send_item(8'h5a, 1'b0);
        settle(DRAIN_CYCLES);

        write_mode(MODE_DECODE);
        run_phase(MODE_DECODE);
        settle(DRAIN_CYCLES);

        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/b32sc_pkg.sv
src/b32sc_front.sv
src/b32sc_queue.sv
src/b32sc_back.sv
src/base32_stream_codec.sv
tb/sv/b32_check_pkg.sv
tb/sv/tb_top.sv
